/* sv/sha1md_pkg.sv */
`default_nettype none

package sha1md_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMPRESS,
        ST_FINAL,
        ST_OUT
    } t_state;

    typedef logic [31:0] t_word;

    // initial chaining value
    localparam t_word H_INIT [0:4] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    // round constants, one per group of twenty rounds
    localparam t_word K_ROUND_0 = 32'h5A82_7999;
    localparam t_word K_ROUND_1 = 32'h6ED9_EBA1;
    localparam t_word K_ROUND_2 = 32'h8F1B_BCDC;
    localparam t_word K_ROUND_3 = 32'hCA62_C1D6;

    // padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam int ROUNDS      = 80;
    localparam int DIGEST_WRDS = 5;

endpackage

`default_nettype wire

/* sv/sha1_message_digest.sv */
// input takes one byte per cycle when not stalled; each completed 64-byte block then stalls it
// while 80 rounds run on one shared round unit, then a chain-add state (load on the last byte)
// message end: padding feeds in the pad bytes (9 to 72), then the digest leaves as five
// beats, one per cycle when not stalled
// input is stalled while a block compresses, pads or the digest drains
// synchronous active-low reset returns the chaining value to its initial words
`default_nettype none

module sha1_message_digest (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_message_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_number,
    output logic             o_final_word
);

    sha1md_pkg::t_state r_state, n_state;

    sha1md_pkg::t_word  r_h [0:4];
    sha1md_pkg::t_word  r_w [0:15];
    sha1md_pkg::t_word  r_a, r_b, r_c, r_d, r_e;
    logic [63:0]        r_bit_len;
    logic [5:0]         r_pos;
    logic [6:0]         r_round;
    logic [2:0]         r_out_idx;
    logic               r_ending;
    logic               r_mark_done;
    logic               r_len_phase;

    logic               in_beat, out_beat;
    logic               put_en;
    logic [7:0]         put_val;
    logic               put_wrap;
    logic [2:0]         len_sel;
    logic [7:0]         len_byte;

    sha1md_pkg::t_word  w_new, w_cur, f_val, k_val, t_sum;

    assign in_beat  = i_valid && !o_stall;
    assign out_beat = o_valid && !i_stall;

    // length byte, most significant first across positions 56 to 63
    assign len_sel  = 3'd7 - r_pos[2:0];
    assign len_byte = r_bit_len[{len_sel, 3'b000} +: 8];

    // next state and byte source
    always_comb begin
        n_state = r_state;
        put_en  = 1'b0;
        put_val = i_data_byte;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            sha1md_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    put_en = i_byte_present;
                    if (i_byte_present && r_pos == 6'd63) begin
                        n_state = sha1md_pkg::ST_COMPRESS;
                    end else if (i_message_end) begin
                        n_state = sha1md_pkg::ST_PAD;
                    end
                end
            end
            sha1md_pkg::ST_PAD: begin
                put_en = 1'b1;
                if (!r_mark_done) begin
                    put_val = sha1md_pkg::PAD_MARK;
                end else if (r_len_phase || r_pos == 6'd56) begin
                    put_val = len_byte;
                end else begin
                    put_val = 8'h00;
                end
                if (r_pos == 6'd63) begin
                    n_state = sha1md_pkg::ST_COMPRESS;
                end
            end
            sha1md_pkg::ST_COMPRESS: begin
                if (r_round == 7'(sha1md_pkg::ROUNDS - 1)) begin
                    n_state = sha1md_pkg::ST_FINAL;
                end
            end
            sha1md_pkg::ST_FINAL: begin
                if (!r_ending) begin
                    n_state = sha1md_pkg::ST_IDLE;
                end else if (r_len_phase) begin
                    n_state = sha1md_pkg::ST_OUT;
                end else begin
                    n_state = sha1md_pkg::ST_PAD;
                end
            end
            sha1md_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall && r_out_idx == 3'(sha1md_pkg::DIGEST_WRDS - 1)) begin
                    n_state = sha1md_pkg::ST_IDLE;
                end
            end
            default: n_state = sha1md_pkg::ST_IDLE;
        endcase
    end

    assign put_wrap = put_en && r_pos == 6'd63;

    // schedule expansion and round function
    assign w_new = {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                    r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
    assign w_cur = (r_round < 7'd16) ? r_w[0] : w_new;

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1md_pkg::K_ROUND_0;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1md_pkg::K_ROUND_1;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1md_pkg::K_ROUND_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1md_pkg::K_ROUND_3;
        end
    end

    assign t_sum = {r_a[26:0], r_a[31:27]} + f_val + r_e + w_cur + k_val;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1md_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and chaining registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_h[i] <= sha1md_pkg::H_INIT[i];
            r_bit_len   <= '0;
            r_pos       <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
            r_ending    <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_phase <= 1'b0;
        end else begin
            if (in_beat) begin
                r_ending <= i_message_end;
                if (i_byte_present) begin
                    r_bit_len <= r_bit_len + 64'd8;
                end
            end
            if (put_en) begin
                r_pos <= r_pos + 6'd1;
            end
            if (put_wrap) begin
                r_round <= '0;
            end else if (r_state == sha1md_pkg::ST_COMPRESS) begin
                r_round <= r_round + 7'd1;
            end
            // padding phase tracking
            if (r_state == sha1md_pkg::ST_PAD) begin
                if (!r_mark_done) begin
                    r_mark_done <= 1'b1;
                end else if (r_pos == 6'd56) begin
                    r_len_phase <= 1'b1;
                end
            end
            // fold the working variables into the chaining value
            if (r_state == sha1md_pkg::ST_FINAL) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            // digest drain, then back to the initial state
            if (out_beat) begin
                if (r_out_idx == 3'(sha1md_pkg::DIGEST_WRDS - 1)) begin
                    for (int i = 0; i < 5; i++) r_h[i] <= sha1md_pkg::H_INIT[i];
                    r_bit_len   <= '0;
                    r_out_idx   <= '0;
                    r_ending    <= 1'b0;
                    r_mark_done <= 1'b0;
                    r_len_phase <= 1'b0;
                end else begin
                    r_out_idx <= r_out_idx + 3'd1;
                end
            end
        end
    end

    // schedule shift line and working variables
    always_ff @(posedge i_clk) begin
        if (put_en) begin
            if (r_pos[1:0] == 2'd0) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= {24'h00_0000, put_val};
            end else begin
                r_w[15] <= {r_w[15][23:0], put_val};
            end
        end else if (r_state == sha1md_pkg::ST_COMPRESS) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_cur;
        end
        if (put_wrap) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_state == sha1md_pkg::ST_COMPRESS) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_digest_word = r_h[r_out_idx];
    assign o_word_number = r_out_idx;
    assign o_final_word  = (r_out_idx == 3'(sha1md_pkg::DIGEST_WRDS - 1));

    // digest is only shown on a block boundary
    a_out_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pos == 6'd0)
        else $error("digest shown off a block boundary");

    // last digest beat restores the initial chaining value
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_final_word) |=>
            (r_state == sha1md_pkg::ST_IDLE && r_h[0] == sha1md_pkg::H_INIT[0]
             && r_bit_len == 64'd0))
        else $error("state not restored after digest");

    // eighty rounds then the chain add
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1md_pkg::ST_COMPRESS && r_round == 7'(sha1md_pkg::ROUNDS - 1))
            |=> r_state == sha1md_pkg::ST_FINAL)
        else $error("compression did not end after last round");

    // length bytes only after the marker byte
    a_len_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_phase |-> (r_mark_done && r_ending))
        else $error("length bytes before marker");

endmodule

`default_nettype wire

/* bench/sha1_message_digest_chk.sv */
`timescale 1ns / 100ps

module sha1_message_digest_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte channel into the block
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_in_data_byte,
    input  wire logic        i_in_byte_present,
    input  wire logic        i_in_message_end,
    // digest channel out of the block
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_out_digest_word,
    input  wire logic [2:0]  i_out_word_number,
    input  wire logic        i_out_final_word,
    output int               o_fail_count,
    output int               o_pending_words,
    output int               o_words_checked
);

    typedef struct packed {
        sha1md_pkg::t_word word;
        logic [2:0]        index;
        logic              last;
    } t_digest_beat;

    // running hash state of the message in flight
    sha1md_pkg::t_word chain_h [0:4];
    sha1md_pkg::t_word sched_w [0:15];
    logic [63:0]       msg_bits;
    logic [5:0]        blk_pos;

    t_digest_beat digest_q[$];
    t_digest_beat beat;
    int           fail_n;
    int           checked_n;

    // back to the initial chaining value for a new message
    task automatic restart_digest();
        for (int n = 0; n < sha1md_pkg::DIGEST_WRDS; n++) begin
            chain_h[n] = sha1md_pkg::H_INIT[n];
        end
        for (int n = 0; n < 16; n++) begin
            sched_w[n] = '0;
        end
        msg_bits = '0;
        blk_pos  = '0;
    endtask

    // 80 rounds over the rolling 16-word schedule, then chain add
    task automatic run_compression();
        sha1md_pkg::t_word a, b, c, d, e, f, k, w, tmp;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < sha1md_pkg::ROUNDS; t++) begin
            if (t >= 16) begin
                w = sched_w[(t + 13) & 15] ^ sched_w[(t + 8) & 15]
                  ^ sched_w[(t + 2) & 15] ^ sched_w[t & 15];
                sched_w[t & 15] = {w[30:0], w[31]};
            end
            w = sched_w[t & 15];
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = sha1md_pkg::K_ROUND_0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_ROUND_1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1md_pkg::K_ROUND_2;
            end else begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_ROUND_3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + w + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endtask

    // big-endian packing, compress on every full block
    task automatic absorb_byte(input logic [7:0] val);
        logic [3:0] slot;
        slot = blk_pos[5:2];
        sched_w[slot] = {sched_w[slot][23:0], val};
        blk_pos = blk_pos + 6'd1;
        if (blk_pos == 6'd0) begin
            run_compression();
        end
    endtask

    // padding, length field and the five digest words
    task automatic close_message();
        logic [63:0]  len_bits;
        t_digest_beat nb;
        len_bits = msg_bits;
        absorb_byte(sha1md_pkg::PAD_MARK);
        while (blk_pos != 6'd56) begin
            absorb_byte(8'h00);
        end
        for (int s = 7; s >= 0; s--) begin
            absorb_byte(len_bits[s*8 +: 8]);
        end
        for (int n = 0; n < sha1md_pkg::DIGEST_WRDS; n++) begin
            nb.word  = chain_h[n];
            nb.index = 3'(n);
            nb.last  = (n == sha1md_pkg::DIGEST_WRDS - 1);
            digest_q.push_back(nb);
        end
        restart_digest();
    endtask

    // predict on accepted bytes, compare accepted digest beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_digest();
            digest_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_byte_present) begin
                    absorb_byte(i_in_data_byte);
                    msg_bits = msg_bits + 64'd8;
                end
                if (i_in_message_end) begin
                    close_message();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest beat, got word %h number %0d final %b",
                             $time, i_out_digest_word, i_out_word_number, i_out_final_word);
                    fail_n++;
                end else begin
                    beat = digest_q.pop_front();
                    checked_n++;
                    if (i_out_digest_word !== beat.word) begin
                        $display("%0t: digest_word mismatch, expected %h, got %h",
                                 $time, beat.word, i_out_digest_word);
                        fail_n++;
                    end
                    if (i_out_word_number !== beat.index) begin
                        $display("%0t: word_number mismatch, expected %0d, got %0d",
                                 $time, beat.index, i_out_word_number);
                        fail_n++;
                    end
                    if (i_out_final_word !== beat.last) begin
                        $display("%0t: final_word mismatch, expected %b, got %b",
                                 $time, beat.last, i_out_final_word);
                        fail_n++;
                    end
                end
            end
        end
        o_fail_count    <= fail_n;
        o_pending_words <= digest_q.size();
        o_words_checked <= checked_n;
    end

endmodule

/* bench/sha1_message_digest_tb.sv */
`timescale 1ns / 100ps

module sha1_message_digest_tb;

    localparam int ITEM_TARGET  = 410;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_message_end  = 1'b0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_number;
    logic        o_final_word;

    int fail_count;
    int pending_words;
    int words_checked;

    int          items_sent;
    int          msgs_sent;
    int          bytes_sent;
    int          longest_msg;
    bit          tx_burst;
    int unsigned rx_hold;
    bit          rx_quiet;
    int          idle_cycles;

    sha1_message_digest i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_message_end  (i_message_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_number  (o_word_number),
        .o_final_word   (o_final_word)
    );

    sha1_message_digest_chk i_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_in_data_byte    (i_data_byte),
        .i_in_byte_present (i_byte_present),
        .i_in_message_end  (i_message_end),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_out_digest_word (o_digest_word),
        .i_out_word_number (o_word_number),
        .i_out_final_word  (o_final_word),
        .o_fail_count      (fail_count),
        .o_pending_words   (pending_words),
        .o_words_checked   (words_checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // digest receiver: stall for a drawn number of valid cycles after each beat
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            rx_hold = rx_quiet ? 0 : $urandom_range(0, 11);
        end else if (o_valid && rx_hold != 0) begin
            rx_hold = rx_hold - 1;
        end
        i_stall <= (rx_hold != 0);
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("** sha1_message_digest: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input beat after a drawn gap; valid only drops when a gap follows
    task automatic send_item(input logic [7:0] val, input logic present, input logic last);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= val;
        i_byte_present <= present;
        i_message_end  <= last;
        do @(posedge i_clk); while (o_stall);
        if (present || last) items_sent++;
        if (present) bytes_sent++;
        if (last) msgs_sent++;
    endtask

    // hold the sender until every digest word has been returned
    task automatic wait_digests_done();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    // random message, ending with its last byte or with a separate empty beat
    task automatic send_message(input int len, input bit end_on_byte);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (n == len - 1));
        end
        if (!end_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
        if (len > longest_msg) longest_msg = len;
    endtask

    // stimulus and verdict
    initial begin
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message
        send_item(8'hC3, 1'b0, 1'b1);
        // single zero byte ending the message
        send_item(8'h00, 1'b1, 1'b1);
        // extremes, an ignored beat, then end without a byte
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        // "abc" with end on the last byte
        tx_burst = 1'b1;
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        tx_burst = 1'b0;
        if (longest_msg < 3) longest_msg = 3;
        wait_digests_done();

        // random messages, mostly short, some around block boundaries
        while (items_sent < ITEM_TARGET) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                7:       len = $urandom_range(52, 68);
                8:       len = $urandom_range(110, 130);
                9: begin
                    case ($urandom_range(0, 5))
                        0:       len = 55;
                        1:       len = 56;
                        2:       len = 63;
                        3:       len = 64;
                        4:       len = 119;
                        default: len = 120;
                    endcase
                end
                default: len = $urandom_range(0, 16);
            endcase
            // keep the total close to the item target
            if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
            send_message(len, $urandom_range(0, 1));
            if (msgs_sent == 10) wait_digests_done();
        end

        // drain the last digest
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d messages, %0d bytes, lengths up to %0d bytes",
                 msgs_sent, bytes_sent, longest_msg);
        $display("%0d digest words compared, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0) begin
            $display("** sha1_message_digest: PASSED **");
        end else begin
            $display("** sha1_message_digest: FAILED **");
        end
        $finish;
    end

endmodule
